@@ hdl/tbs_pkg.sv @@
// Package for the two-button mode and digit setter.
// Field widths, mode codes, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps

package tbs_pkg;

    localparam int MODE_W     = 2;
    localparam int LOW_W      = 4;
    localparam int HIGH_W     = 2;
    localparam int TICK_CNT_W = 10;
    localparam int CFG_IDX_W  = 2;

    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [LOW_W-1:0]      low_digit_t;
    typedef logic [HIGH_W-1:0]     high_digit_t;
    typedef logic [TICK_CNT_W-1:0] tick_cnt_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    localparam mode_t MODE_RUN      = 2'd0;
    localparam mode_t MODE_SET_LOW  = 2'd1;
    localparam mode_t MODE_SET_HIGH = 2'd2;

    localparam cfg_idx_t CFG_LONG_HOLD = 2'd0;
    localparam cfg_idx_t CFG_SHORT_MIN = 2'd1;
    localparam cfg_idx_t CFG_REPEAT    = 2'd2;

    localparam tick_cnt_t LONG_HOLD_RST = 10'd400;
    localparam tick_cnt_t SHORT_MIN_RST = 10'd10;
    localparam tick_cnt_t REPEAT_RST    = 10'd40;
    localparam tick_cnt_t COUNT_MAX     = 10'd1023;

    localparam low_digit_t  LOW_WRAP  = 4'b1111;
    localparam high_digit_t HIGH_WRAP = 2'b11;

    // Saturating increment of a hold counter.
    function automatic tick_cnt_t count_up(input tick_cnt_t c);
        return (c == COUNT_MAX) ? c : c + tick_cnt_t'(1);
    endfunction

endpackage

@@ hdl/tbs_if.sv @@
// Channel interfaces for the two-button mode and digit setter.
// Depends on tbs_pkg for the field widths.
`timescale 1ns / 1ps

interface tbs_in_if;
    import tbs_pkg::*;

    logic valid;
    logic ready;
    logic mode_button;
    logic adjust_button;

    modport source (output valid, output mode_button, output adjust_button, input ready);
    modport sink   (input valid, input mode_button, input adjust_button, output ready);
endinterface

interface tbs_out_if;
    import tbs_pkg::*;

    logic        valid;
    logic        ready;
    mode_t       current_mode;
    low_digit_t  low_value;
    high_digit_t high_value;

    modport source (output valid, output current_mode, output low_value, output high_value,
                    input ready);
    modport sink   (input valid, input current_mode, input low_value, input high_value,
                    output ready);
endinterface

@@ hdl/two_button_mode_and_digit_setter.sv @@
// Channel   | Dir | Payload                                  | Handshake
// tick      | in  | mode_button, adjust_button               | valid/ready
// result    | out | current_mode, low_value, high_value      | valid/ready
// cfg       | in  | cfg_index, cfg_data                      | cfg_we, no wait
//
// One item per clock while the result is not stalled; an item passes the input register, then the result register.
// The state update for a tick is a single pass of compares and small counters.
// Reset: run mode, digits and counters zero, thresholds 400 / 10 / 40.
// A stalled result holds the input register; one item waits there before tick.ready drops.
// Depends on tbs_pkg and tbs_if.
`timescale 1ns / 1ps

module two_button_mode_and_digit_setter (
    input  logic                  clk,
    input  logic                  rst_n,
    tbs_in_if.sink                tick,
    tbs_out_if.source             result,
    input  logic                  cfg_we,
    input  tbs_pkg::cfg_idx_t     cfg_index,
    input  tbs_pkg::tick_cnt_t    cfg_data
);
    import tbs_pkg::*;

    // configuration
    tick_cnt_t long_hold_reg;
    tick_cnt_t short_min_reg;
    tick_cnt_t repeat_reg;

    // input register
    logic s1_valid_reg;
    logic s1_mode_button_reg;
    logic s1_adjust_button_reg;

    // block state
    mode_t       mode_reg, mode_next;
    low_digit_t  low_digit_reg, low_digit_next;
    high_digit_t high_digit_reg, high_digit_next;
    tick_cnt_t   mode_count_reg, mode_count_next;
    logic        adjust_armed_reg, adjust_armed_next;
    tick_cnt_t   adjust_count_reg, adjust_count_next;

    // result register
    logic        out_valid_reg;
    mode_t       out_mode_reg;
    low_digit_t  out_low_reg;
    high_digit_t out_high_reg;

    logic      advance;
    logic      mode_armed;
    tick_cnt_t mode_cnt_up;
    logic      adj_arm_now;
    logic      adj_armed;
    tick_cnt_t adj_cnt_base;
    tick_cnt_t adj_cnt_up;
    logic      adj_step;

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !s1_valid_reg || advance;

    assign result.valid        = out_valid_reg;
    assign result.current_mode = out_mode_reg;
    assign result.low_value    = out_low_reg;
    assign result.high_value   = out_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_reg <= LONG_HOLD_RST;
            short_min_reg <= SHORT_MIN_RST;
            repeat_reg    <= REPEAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LONG_HOLD: long_hold_reg <= cfg_data;
                CFG_SHORT_MIN: short_min_reg <= cfg_data;
                CFG_REPEAT:    repeat_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Mode button: armed level is just the current level; the count survives early releases.
    always_comb
    begin
        mode_armed      = s1_mode_button_reg;
        mode_cnt_up     = mode_armed ? count_up(mode_count_reg) : mode_count_reg;
        mode_next       = mode_reg;
        mode_count_next = mode_cnt_up;
        if (mode_armed && (mode_cnt_up >= long_hold_reg))
        begin
            case (mode_reg)
                MODE_RUN:     mode_next = MODE_SET_LOW;
                MODE_SET_LOW: mode_next = MODE_RUN;
                default:      mode_next = mode_reg;
            endcase
            mode_count_next = '0;
        end
        else if (!mode_armed && (mode_cnt_up > short_min_reg) && (mode_cnt_up < long_hold_reg))
        begin
            case (mode_reg)
                MODE_SET_LOW:  mode_next = MODE_SET_HIGH;
                MODE_SET_HIGH: mode_next = MODE_SET_LOW;
                default:       mode_next = MODE_RUN;
            endcase
            mode_count_next = '0;
        end
    end

    // Adjust button: a fresh press loads 1 and then counts, so the first step
    // comes a tick earlier than later repeats.
    always_comb
    begin
        adj_arm_now       = s1_adjust_button_reg && !adjust_armed_reg;
        adj_armed         = adj_arm_now || adjust_armed_reg;
        adj_cnt_base      = adj_arm_now ? tick_cnt_t'(1) : adjust_count_reg;
        adj_cnt_up        = adj_armed ? count_up(adj_cnt_base) : adj_cnt_base;
        adj_step          = adj_cnt_up > repeat_reg;
        adjust_count_next = adj_step ? '0 : adj_cnt_up;
        adjust_armed_next = adj_armed && s1_adjust_button_reg;

        low_digit_next  = low_digit_reg;
        high_digit_next = high_digit_reg;
        if (adj_step)
        begin
            case (mode_next)
                MODE_SET_LOW:
                    low_digit_next = (low_digit_reg == LOW_WRAP) ? '0
                                     : low_digit_reg + low_digit_t'(1);
                MODE_SET_HIGH:
                    high_digit_next = (high_digit_reg == HIGH_WRAP) ? '0
                                      : high_digit_reg + high_digit_t'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            mode_reg         <= MODE_RUN;
            low_digit_reg    <= '0;
            high_digit_reg   <= '0;
            mode_count_reg   <= '0;
            adjust_armed_reg <= 1'b0;
            adjust_count_reg <= '0;
        end
        else
        begin
            if (tick.ready)
            begin
                s1_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                mode_reg         <= mode_next;
                low_digit_reg    <= low_digit_next;
                high_digit_reg   <= high_digit_next;
                mode_count_reg   <= mode_count_next;
                adjust_armed_reg <= adjust_armed_next;
                adjust_count_reg <= adjust_count_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s1_mode_button_reg   <= tick.mode_button;
            s1_adjust_button_reg <= tick.adjust_button;
        end
        if (advance)
        begin
            out_mode_reg <= mode_next;
            out_low_reg  <= low_digit_next;
            out_high_reg <= high_digit_next;
        end
    end

    // Input side stalls only with an item held and the result stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("tick stalled without a held item and stalled result");

    // A mode change always consumes the mode-button count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (mode_next != mode_reg)) |=> (mode_count_reg == '0))
        else $error("mode changed but mode count not cleared");

    // Digits move only in their set mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (low_digit_next != low_digit_reg)) |-> (mode_next == MODE_SET_LOW))
        else $error("low digit stepped outside set-low");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (high_digit_next != high_digit_reg)) |-> (mode_next == MODE_SET_HIGH))
        else $error("high digit stepped outside set-high");

    // A shown result matches the state it left behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.current_mode == mode_reg)
                          && (result.low_value == low_digit_reg)
                          && (result.high_value == high_digit_reg)))
        else $error("result register out of step with state");

endmodule
